@@ sv/line_follow_pid_steering_defines.svh @@
// Assertion macros shared by the line-follower steering RTL.
`ifndef LINE_FOLLOW_PID_STEERING_DEFINES_SVH
`define LINE_FOLLOW_PID_STEERING_DEFINES_SVH
`ifndef SYNTH
// Check a property on every clock edge outside reset
`define LFPS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds outside reset
`define LFPS_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define LFPS_ASSERT(label, clk, rst_n, prop, msg)
`define LFPS_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

@@ sv/lfps_pkg.sv @@
// Types and constants of the line-follower PID steering block.
package lfps_pkg;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P     = 3'd0,
    CFG_GAIN_I     = 3'd1,
    CFG_GAIN_D     = 3'd2,
    CFG_BASE_SPEED = 3'd3,
    CFG_END_THR    = 3'd4,
    CFG_CONF_LIMIT = 3'd5
  } cfg_reg_e;

  // Register reset values
  localparam logic [15:0] RST_GAIN_P     = 16'd1280;
  localparam logic [15:0] RST_GAIN_I     = 16'd0;
  localparam logic [15:0] RST_GAIN_D     = 16'd13;
  localparam logic [15:0] RST_BASE_SPEED = 16'd13107;
  localparam logic [7:0]  RST_END_THR    = 8'd125;
  localparam logic [7:0]  RST_CONF_LIMIT = 8'd30;

  // Fixed-point constants
  localparam int unsigned ONE_Q12 = 4096;
  localparam int unsigned ROM_W   = 14;   // normalized or scaled count, unsigned
  localparam int unsigned A_W     = 16;   // multiplier operand a: gain or weight
  localparam int unsigned B_W     = 17;   // multiplier operand b: error term
  localparam int unsigned PROD_W  = A_W + B_W;
  localparam int unsigned ACC_W   = 35;

  localparam logic signed [A_W-1:0] W_FAR_LEFT  = -16'sd3;
  localparam logic signed [A_W-1:0] W_MID_LEFT  = -16'sd1;
  localparam logic signed [A_W-1:0] W_MID_RIGHT = 16'sd1;
  localparam logic signed [A_W-1:0] W_FAR_RIGHT = 16'sd1;  // scaling lives in the table

  localparam logic signed [13:0] INT_MAX = 14'sd4096;
  localparam logic signed [13:0] INT_MIN = -14'sd4096;
  localparam logic [15:0] FULL_SPEED = 16'd32768;

  // Control of the shared multiply-accumulate unit
  typedef struct packed {
    logic clr;   // zero the accumulator
    logic mul;   // form a product, added to the accumulator in the next cycle
  } mac_ctl_t;

endpackage

@@ sv/lfps_norm_rom.sv @@
// Constant table: saturated and normalized sensor counts, registered read.
module lfps_norm_rom #(
  parameter int unsigned MAX_COUNT = 250
) (
  input  logic                       clk_i,
  input  logic [7:0]                 cnt_i,
  input  logic                       far_i,
  output logic [lfps_pkg::ROM_W-1:0] data_o
);
  import lfps_pkg::*;

  logic [12:0]      norm_tab [256];
  logic [ROM_W-1:0] far_tab  [256];
  logic [ROM_W-1:0] data_q;

  // Build Q.12 count and 2.6x scaled Q.12 count per raw value
  for (genvar g = 0; g < 256; g++) begin : g_tab
    localparam int unsigned C = (g > MAX_COUNT) ? MAX_COUNT : g;
    localparam int unsigned N = (C * ONE_Q12 + MAX_COUNT / 2) / MAX_COUNT;
    localparam int unsigned W = (26 * N + 5) / 10;
    assign norm_tab[g] = 13'(N);
    assign far_tab[g]  = ROM_W'(W);
  end

  // Register the selected entry
  always_ff @(posedge clk_i) begin
    if (far_i) begin
      data_q <= far_tab[cnt_i];
    end else begin
      data_q <= {1'b0, norm_tab[cnt_i]};
    end
  end

  assign data_o = data_q;

endmodule

@@ sv/lfps_mac.sv @@
// Shared signed multiply-accumulate unit with a registered product.
module lfps_mac (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  lfps_pkg::mac_ctl_t                 ctl_i,
  input  logic signed [lfps_pkg::A_W-1:0]    a_i,
  input  logic signed [lfps_pkg::B_W-1:0]    b_i,
  output logic signed [lfps_pkg::ACC_W-1:0]  acc_o
);
  import lfps_pkg::*;

  logic signed [PROD_W-1:0] prod_q;
  logic                     pend_q;
  logic signed [ACC_W-1:0]  acc_q;

  // Multiply, then fold the product into the accumulator next cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      acc_q  <= '0;
    end else begin
      pend_q <= ctl_i.mul;
      if (ctl_i.clr) begin
        acc_q <= '0;
      end else if (pend_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul) begin
      prod_q <= a_i * b_i;
    end
  end

  assign acc_o = acc_q;

endmodule

@@ sv/line_follow_pid_steering.sv @@
// Top level of the line-follower PID steering block: sequencer, state and ports.
// From acceptance of a sample of four sensor counts to the result register, the weighted
// line error is built from four table lookups run through one shared 16x17 multiplier
// with a product register, then the P, I and D terms run through the same multiplier, and
// a last step rounds, clamps and splits the steer into the two motor speeds. s_axis_tready
// is high only while the sequencer is idle, so the block takes no new sample until it is
// done with the last one; a finished result waits in the output register without holding
// off the next sample, and the sequencer stalls in its last step only if the previous
// result has not yet been taken. Registers are written through the cfg port, by the user
// only while the block is idle; the block itself does not enforce this.
`include "line_follow_pid_steering_defines.svh"

module line_follow_pid_steering #(
  parameter int unsigned MAX_COUNT = 250
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lfps_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lfps_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // sensor_far_left[7:0], sensor_mid_left[15:8], sensor_mid_right[23:16],
  // sensor_far_right[31:24]
  input  logic [31:0]                       s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // left_speed[15:0], right_speed[31:16], steer_value[48:32], line_end[49], zero[55:50]
  output logic [55:0]                       m_axis_tdata
);
  import lfps_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_DRAIN, ST_ERR,
    ST_MULP, ST_MULI, ST_MULD, ST_DRAIN2, ST_STEER
  } state_e;

  localparam logic [7:0] MAX_CNT8 = 8'(MAX_COUNT);

  state_e state_q, state_d;

  // Configuration registers
  logic signed [15:0] gain_p_q, gain_i_q, gain_d_q;
  logic [15:0]        base_q;
  logic [7:0]         thr_q, limit_q;

  // Loop state and per-sample registers
  logic signed [13:0] integ_q;
  logic signed [15:0] last_q;
  logic signed [16:0] deriv_q;
  logic [7:0]         idle_q;
  logic               end_q;
  logic [23:0]        sens_q;
  logic               out_valid_q;
  logic [55:0]        out_data_q;

  // Datapath signals
  logic                    accept;
  logic                    out_free;
  logic [7:0]              rom_cnt;
  logic                    rom_far;
  logic [ROM_W-1:0]        rom_data;
  mac_ctl_t                mac_ctl;
  logic signed [A_W-1:0]   mac_a;
  logic signed [B_W-1:0]   mac_b;
  logic signed [ACC_W-1:0] acc;
  logic signed [15:0]      err;
  logic signed [16:0]      int_sum;
  logic signed [13:0]      int_new;
  logic signed [16:0]      deriv_new;
  logic [7:0]              mid_l_sat, mid_r_sat;
  logic                    no_line;
  logic [7:0]              idle_new;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [29:0]      steer_wide;
  logic signed [29:0]      base_wide;
  logic signed [17:0]      steer;
  logic signed [18:0]      left_raw, right_raw;
  logic [15:0]             left_spd, right_spd;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign out_free      = !out_valid_q || m_axis_tready;

  // Table lookup, one sensor per cycle, in the cycle before its product
  always_comb begin
    rom_cnt = s_axis_tdata[7:0];
    rom_far = 1'b0;
    case (state_q)
      ST_MUL0: rom_cnt = sens_q[7:0];
      ST_MUL1: rom_cnt = sens_q[15:8];
      ST_MUL2: begin
        rom_cnt = sens_q[23:16];
        rom_far = 1'b1;
      end
      default: rom_cnt = s_axis_tdata[7:0];
    endcase
  end

  lfps_norm_rom #(
    .MAX_COUNT(MAX_COUNT)
  ) u_rom (
    .clk_i (clk_i),
    .cnt_i (rom_cnt),
    .far_i (rom_far),
    .data_o(rom_data)
  );

  // Operand selection for the shared multiplier
  always_comb begin
    mac_ctl = '0;
    mac_a   = '0;
    mac_b   = B_W'(signed'({1'b0, rom_data}));
    case (state_q)
      ST_IDLE: mac_ctl.clr = 1'b1;
      ST_ERR:  mac_ctl.clr = 1'b1;
      ST_MUL0: begin
        mac_ctl.mul = 1'b1;
        mac_a       = W_FAR_LEFT;
      end
      ST_MUL1: begin
        mac_ctl.mul = 1'b1;
        mac_a       = W_MID_LEFT;
      end
      ST_MUL2: begin
        mac_ctl.mul = 1'b1;
        mac_a       = W_MID_RIGHT;
      end
      ST_MUL3: begin
        mac_ctl.mul = 1'b1;
        mac_a       = W_FAR_RIGHT;
      end
      ST_MULP: begin
        mac_ctl.mul = 1'b1;
        mac_a       = gain_p_q;
        mac_b       = B_W'(last_q);
      end
      ST_MULI: begin
        mac_ctl.mul = 1'b1;
        mac_a       = gain_i_q;
        mac_b       = B_W'(integ_q);
      end
      ST_MULD: begin
        mac_ctl.mul = 1'b1;
        mac_a       = gain_d_q;
        mac_b       = deriv_q;
      end
      default: mac_ctl = '0;
    endcase
  end

  lfps_mac u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (mac_ctl),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .acc_o (acc)
  );

  // Integral and derivative update from the finished error
  assign err       = acc[15:0];
  assign int_sum   = 17'(integ_q) + 17'(err);
  assign int_new   = (int_sum > 17'(INT_MAX)) ? INT_MAX :
                     (int_sum < 17'(INT_MIN)) ? INT_MIN : int_sum[13:0];
  assign deriv_new = 17'(err) - 17'(last_q);

  // No-line test on the saturated middle counts
  assign mid_l_sat = (s_axis_tdata[15:8] > MAX_CNT8) ? MAX_CNT8 : s_axis_tdata[15:8];
  assign mid_r_sat = (s_axis_tdata[23:16] > MAX_CNT8) ? MAX_CNT8 : s_axis_tdata[23:16];
  assign no_line   = (mid_l_sat < thr_q) && (mid_r_sat < thr_q);
  assign idle_new  = (idle_q == 8'hFF) ? idle_q : idle_q + 8'd1;

  // Round to Q.15, clamp to base speed, split into motor speeds
  assign acc_rnd    = acc + ACC_W'(16);
  assign steer_wide = acc_rnd[ACC_W-1:5];
  assign base_wide  = 30'(signed'({1'b0, base_q}));
  assign steer      = (steer_wide > base_wide)  ? 18'(base_wide) :
                      (steer_wide < -base_wide) ? 18'(-base_wide) : steer_wide[17:0];
  assign left_raw   = 19'(signed'({1'b0, base_q})) - 19'(steer);
  assign right_raw  = 19'(signed'({1'b0, base_q})) + 19'(steer);
  assign left_spd   = (left_raw < 19'sd0) ? 16'd0 :
                      (left_raw > 19'(signed'({1'b0, FULL_SPEED}))) ? FULL_SPEED :
                      left_raw[15:0];
  assign right_spd  = (right_raw < 19'sd0) ? 16'd0 :
                      (right_raw > 19'(signed'({1'b0, FULL_SPEED}))) ? FULL_SPEED :
                      right_raw[15:0];

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (accept) state_d = ST_MUL0;
      ST_MUL0:   state_d = ST_MUL1;
      ST_MUL1:   state_d = ST_MUL2;
      ST_MUL2:   state_d = ST_MUL3;
      ST_MUL3:   state_d = ST_DRAIN;
      ST_DRAIN:  state_d = ST_ERR;
      ST_ERR:    state_d = ST_MULP;
      ST_MULP:   state_d = ST_MULI;
      ST_MULI:   state_d = ST_MULD;
      ST_MULD:   state_d = ST_DRAIN2;
      ST_DRAIN2: state_d = ST_STEER;
      ST_STEER:  if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Hold state, configuration, loop state and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gain_p_q    <= RST_GAIN_P;
      gain_i_q    <= RST_GAIN_I;
      gain_d_q    <= RST_GAIN_D;
      base_q      <= RST_BASE_SPEED;
      thr_q       <= RST_END_THR;
      limit_q     <= RST_CONF_LIMIT;
      integ_q     <= '0;
      last_q      <= '0;
      idle_q      <= '0;
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_GAIN_P:     gain_p_q <= cfg_data_i;
          CFG_GAIN_I:     gain_i_q <= cfg_data_i;
          CFG_GAIN_D:     gain_d_q <= cfg_data_i;
          CFG_BASE_SPEED: base_q   <= cfg_data_i;
          CFG_END_THR:    thr_q    <= cfg_data_i[7:0];
          CFG_CONF_LIMIT: limit_q  <= cfg_data_i[7:0];
          default: ;
        endcase
      end

      if (accept) begin
        if (no_line) begin
          idle_q <= idle_new;
          end_q  <= (idle_new >= limit_q);
        end else begin
          idle_q <= '0;
          end_q  <= 1'b0;
        end
      end

      if (state_q == ST_ERR) begin
        integ_q <= int_new;
        last_q  <= err;
      end

      if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if ((state_q == ST_STEER) && out_free) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      sens_q <= s_axis_tdata[31:8];
    end
    if (state_q == ST_ERR) begin
      deriv_q <= deriv_new;
    end
    if ((state_q == ST_STEER) && out_free) begin
      out_data_q <= {6'b0, end_q, steer[16:0], right_spd, left_spd};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  `LFPS_ASSERT(a_start_seq, clk_i, rst_ni, accept |=> state_q == ST_MUL0,
               "accepted sample did not start the sequencer")
  `LFPS_ASSERT_NEVER(a_integ_range, clk_i, rst_ni,
                     (integ_q > INT_MAX) || (integ_q < INT_MIN),
                     "integral left its clamp range")
  `LFPS_ASSERT(a_result_src, clk_i, rst_ni,
               $rose(out_valid_q) |-> $past(state_q == ST_STEER),
               "result appeared outside the final step")
  `LFPS_ASSERT(a_steer_done, clk_i, rst_ni,
               (state_q == ST_STEER) && out_free |=> out_valid_q && (state_q == ST_IDLE),
               "final step did not load the result")

endmodule
